// ===== hw/rtl/sdpg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdpg_pkg
// Shared types and constants for the step/direction pulse generator.
// ----------------------------------------------------------------------------
package sdpg_pkg;

  // default sizes of the position and elapsed-time counters
  localparam int SDPG_POSITION_BITS = 24;
  localparam int SDPG_DELAY_BITS    = 20;

  // configuration register widths and reset values
  localparam int HALF_PERIOD_W = 20;
  localparam int TOLERANCE_W   = 8;
  localparam int CFG_DATA_W    = HALF_PERIOD_W;
  localparam int CFG_IDX_W     = 1;

  localparam logic [HALF_PERIOD_W-1:0] HALF_PERIOD_RST = HALF_PERIOD_W'(1000);
  localparam logic [TOLERANCE_W-1:0]   TOLERANCE_RST   = TOLERANCE_W'(1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HALF_PERIOD = 1'b0,
    CFG_TOLERANCE   = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    OP_TICK       = 2'd0,
    OP_SET_TARGET = 2'd1,
    OP_CALIBRATE  = 2'd2
  } op_t;

  // status bits of one result transaction
  typedef struct packed {
    logic step_level;
    logic direction_cw;
    logic moving;
    logic target_refused;
  } status_t;

endpackage

// ===== hw/rtl/sdpg_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdpg_core
// Motion state and its update for each accepted transaction.
// ----------------------------------------------------------------------------
module sdpg_core import sdpg_pkg::*; #(
  parameter int POSITION_BITS = SDPG_POSITION_BITS,
  parameter int DELAY_BITS    = SDPG_DELAY_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            accept,
  input  logic [1:0]                      operation,
  input  logic signed [POSITION_BITS-1:0] target_step,
  input  logic [HALF_PERIOD_W-1:0]        half_period,
  input  logic [TOLERANCE_W-1:0]          tolerance,
  output logic signed [POSITION_BITS-1:0] position_nxt,
  output status_t                         status_nxt
);

  localparam int CMP_W = (DELAY_BITS > HALF_PERIOD_W) ? DELAY_BITS : HALF_PERIOD_W;

  logic signed [POSITION_BITS-1:0] pos_r, tgt_r, tgt_nxt;
  logic                            level_r, level_nxt;
  logic                            dir_r, dir_nxt;
  logic [DELAY_BITS-1:0]           elapsed_r, elapsed_nxt, elapsed_inc;
  logic                            moving_now;
  logic                            refused;

  // |a - b| >= tol, evaluated one bit wider so the difference never wraps
  function automatic logic dist_ge(input logic signed [POSITION_BITS-1:0] a,
                                   input logic signed [POSITION_BITS-1:0] b,
                                   input logic [TOLERANCE_W-1:0] tol);
    logic signed [POSITION_BITS:0] d;
    logic [POSITION_BITS:0]        mag;
    d   = $signed({a[POSITION_BITS-1], a}) - $signed({b[POSITION_BITS-1], b});
    mag = d[POSITION_BITS] ? (POSITION_BITS+1)'(-d) : (POSITION_BITS+1)'(d);
    return mag >= (POSITION_BITS+1)'(tol);
  endfunction

  assign moving_now  = dist_ge(pos_r, tgt_r, tolerance);
  // saturating elapsed count
  assign elapsed_inc = (elapsed_r == {DELAY_BITS{1'b1}}) ? elapsed_r
                                                         : elapsed_r + DELAY_BITS'(1);

  always_comb begin
    position_nxt = pos_r;
    tgt_nxt      = tgt_r;
    level_nxt    = level_r;
    dir_nxt      = dir_r;
    elapsed_nxt  = elapsed_r;
    refused      = 1'b0;
    case (operation)
      OP_TICK: begin
        elapsed_nxt = elapsed_inc;
        if (moving_now && (CMP_W'(elapsed_inc) > CMP_W'(half_period))) begin
          level_nxt   = ~level_r;
          elapsed_nxt = '0;
          // falling edge of the step pin advances the position
          if (level_r) begin
            if (pos_r < tgt_r) begin
              position_nxt = pos_r + POSITION_BITS'(1);
            end else begin
              position_nxt = pos_r - POSITION_BITS'(1);
            end
          end
        end
      end
      OP_SET_TARGET: begin
        if (moving_now) begin
          refused = 1'b1;
        end else begin
          tgt_nxt = target_step;
          dir_nxt = (target_step > pos_r);
        end
      end
      OP_CALIBRATE: begin
        position_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  assign status_nxt.step_level     = level_nxt;
  assign status_nxt.direction_cw   = dir_nxt;
  assign status_nxt.moving         = dist_ge(position_nxt, tgt_nxt, tolerance);
  assign status_nxt.target_refused = refused;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      tgt_r     <= '0;
      level_r   <= 1'b0;
      dir_r     <= 1'b0;
      elapsed_r <= '0;
    end else if (accept) begin
      pos_r     <= position_nxt;
      tgt_r     <= tgt_nxt;
      level_r   <= level_nxt;
      dir_r     <= dir_nxt;
      elapsed_r <= elapsed_nxt;
    end
  end

endmodule

// ===== hw/rtl/stepper_step_dir_pulse_generator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_step_dir_pulse_generator
// Step/direction pulse generator driven by tick, set-target and calibrate
// transactions; one status transaction out per transaction in.
// ----------------------------------------------------------------------------
// Output is registered: out_valid rises in the cycle after input acceptance.
// Throughput: 1 transaction per cycle while out_stall is low; the motion state updates
//   in one pass and the output register is reloaded in the same cycle it is drained.
// Reset (rst_n low, synchronous): position, target, step level, direction
//   and elapsed count clear; half-period returns to 1000, tolerance to 1.
module stepper_step_dir_pulse_generator import sdpg_pkg::*; #(
  parameter int POSITION_BITS = SDPG_POSITION_BITS,
  parameter int DELAY_BITS    = SDPG_DELAY_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [CFG_IDX_W-1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0]           cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_operation,
  input  logic signed [POSITION_BITS-1:0] in_target_step,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_step_level,
  output logic                            out_direction_cw,
  output logic                            out_moving,
  output logic signed [POSITION_BITS-1:0] out_position,
  output logic                            out_target_refused
);

  logic [HALF_PERIOD_W-1:0]        half_period_r;
  logic [TOLERANCE_W-1:0]          tolerance_r;
  logic                            in_accept;
  logic                            out_valid_r;
  status_t                         status_nxt, status_r;
  logic signed [POSITION_BITS-1:0] position_nxt, position_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_period_r <= HALF_PERIOD_RST;
      tolerance_r   <= TOLERANCE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HALF_PERIOD: half_period_r <= cfg_wdata[HALF_PERIOD_W-1:0];
        CFG_TOLERANCE:   tolerance_r   <= cfg_wdata[TOLERANCE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // take a new transaction whenever the output register is empty or draining
  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;

  sdpg_core #(
    .POSITION_BITS(POSITION_BITS),
    .DELAY_BITS   (DELAY_BITS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_accept),
    .operation   (in_operation),
    .target_step (in_target_step),
    .half_period (half_period_r),
    .tolerance   (tolerance_r),
    .position_nxt(position_nxt),
    .status_nxt  (status_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      status_r   <= status_nxt;
      position_r <= position_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_step_level     = status_r.step_level;
  assign out_direction_cw   = status_r.direction_cw;
  assign out_moving         = status_r.moving;
  assign out_position       = position_r;
  assign out_target_refused = status_r.target_refused;

  // an accepted transaction always shows up at the output next cycle
  a_accept_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> out_valid_r)
    else $error("accepted transaction did not reach the output register");

  // a refused target leaves the state untouched, so the motor is still moving
  a_refused_moving: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_target_refused) |-> out_moving)
    else $error("target refused while not moving");

  // calibrate always reports position zero
  a_calibrate_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && (in_operation == OP_CALIBRATE)) |=> (out_position == '0))
    else $error("calibrate did not zero the position");

endmodule

// ===== sim/stepper_step_dir_pulse_generator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_step_dir_pulse_generator_tb
// Self-checking bench: a short directed run, then random tick, set-target,
// calibrate and reserved-opcode transactions across several
// half-period/tolerance settings and stall patterns. A predictor tracks the
// motion state and every result transaction is checked in order against it.
// ----------------------------------------------------------------------------
import sdpg_pkg::*;

typedef logic signed [SDPG_POSITION_BITS-1:0] steps_t;

typedef struct packed {
  logic   step_level;
  logic   direction_cw;
  logic   moving;
  steps_t position;
  logic   target_refused;
} motion_status_t;

class motion_scoreboard;
  steps_t                     cur_position;
  steps_t                     goal_position;
  logic                       pulse;
  logic                       dir_cw;
  logic [SDPG_DELAY_BITS-1:0] elapsed;
  logic [HALF_PERIOD_W-1:0]   half_period;
  logic [TOLERANCE_W-1:0]     tolerance;
  motion_status_t             expected_status[$];
  int                         mismatches;

  function new();
    cur_position  = '0;
    goal_position = '0;
    pulse         = 1'b0;
    dir_cw        = 1'b0;
    elapsed       = '0;
    half_period   = HALF_PERIOD_RST;
    tolerance     = TOLERANCE_RST;
    mismatches    = 0;
  endfunction

  function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
    if (idx == CFG_HALF_PERIOD) begin
      half_period = value[HALF_PERIOD_W-1:0];
    end else begin
      tolerance = value[TOLERANCE_W-1:0];
    end
  endfunction

  // distance is taken on full-width integers, no wrap
  function bit moving();
    longint delta;
    delta = longint'(cur_position) - longint'(goal_position);
    if (delta < 0) delta = -delta;
    return delta >= longint'(tolerance);
  endfunction

  function void note_transaction(logic [1:0] op, steps_t target);
    motion_status_t s;
    s.target_refused = 1'b0;
    case (op)
      OP_TICK: begin
        if (elapsed != '1) elapsed = elapsed + 1'b1;
        if (moving() && elapsed > half_period) begin
          pulse   = ~pulse;
          elapsed = '0;
          // falling edge of the step pin moves one step
          if (!pulse) begin
            if (cur_position < goal_position) cur_position = cur_position + steps_t'(1);
            else cur_position = cur_position - steps_t'(1);
          end
        end
      end
      OP_SET_TARGET: begin
        if (moving()) begin
          s.target_refused = 1'b1;
        end else begin
          goal_position = target;
          dir_cw        = (goal_position > cur_position);
        end
      end
      OP_CALIBRATE: cur_position = '0;
      default: ;
    endcase
    s.step_level   = pulse;
    s.direction_cw = dir_cw;
    s.moving       = moving();
    s.position     = cur_position;
    expected_status.push_back(s);
  endfunction

  function void check_result(logic lvl, logic dir, logic mov, steps_t pos, logic refused);
    motion_status_t want;
    if (expected_status.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: lvl=%0b dir=%0b mov=%0b pos=%0d refused=%0b",
                 lvl, dir, mov, pos, refused);
      return;
    end
    want = expected_status.pop_front();
    if (lvl !== want.step_level || dir !== want.direction_cw || mov !== want.moving ||
        pos !== want.position || refused !== want.target_refused) begin
      mismatches++;
      if (mismatches <= 10)
        $display({"result mismatch: exp lvl=%0b dir=%0b mov=%0b pos=%0d refused=%0b",
                  " | got lvl=%0b dir=%0b mov=%0b pos=%0d refused=%0b"},
                 want.step_level, want.direction_cw, want.moving, want.position,
                 want.target_refused, lvl, dir, mov, pos, refused);
    end
  endfunction

  function int pending();
    return expected_status.size();
  endfunction
endclass

module stepper_step_dir_pulse_generator_tb;

  localparam longint     CYCLE_LIMIT   = 4_000_000;
  localparam int         SETTLE_CYCLES = 4;
  localparam int         SEGMENTS      = 9;
  localparam int         SEGMENT_ITEMS = 150;
  localparam logic [1:0] OP_RESERVED   = 2'd3;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  cfg_idx_t              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_stall;
  logic [1:0]            in_operation;
  steps_t                in_target_step;
  logic                  out_valid;
  logic                  out_stall;
  logic                  out_step_level;
  logic                  out_direction_cw;
  logic                  out_moving;
  steps_t                out_position;
  logic                  out_target_refused;

  motion_scoreboard sb;
  int     tx_idle_pct;
  int     rx_idle_pct;
  longint cycles;

  // per-segment settings: zero and maximum values, large half-period, zero tolerance
  int half_by_segment [SEGMENTS] = '{1, 0, 2, 1000000, 0, 3, 1048575, 5, 1};
  int tol_by_segment  [SEGMENTS] = '{1, 0, 3, 255, 255, 2, 1, 4, 1};

  stepper_step_dir_pulse_generator u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_operation       (in_operation),
    .in_target_step     (in_target_step),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_step_level     (out_step_level),
    .out_direction_cw   (out_direction_cw),
    .out_moving         (out_moving),
    .out_position       (out_position),
    .out_target_refused (out_target_refused)
  );

  always #6 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < rx_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_step_level, out_direction_cw, out_moving, out_position,
                      out_target_refused);
  end

  always @(posedge clk) begin
    cycles = cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_item(logic [1:0] op, steps_t target);
    @(negedge clk);
    // sender idles cycle by cycle
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_operation   <= op;
    in_target_step <= target;
    do @(posedge clk); while (in_stall);
    sb.note_transaction(op, target);
  endtask

  task automatic send_ticks(int n);
    repeat (n) send_item(OP_TICK, '0);
  endtask

  task automatic drain_pipeline();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, value);
  endtask

  // mostly ticks; targets land near the current position so moves finish,
  // with full-range targets mixed in while moving (those get refused)
  task automatic send_random_item();
    int     roll;
    int     span;
    steps_t target;
    roll   = $urandom_range(99);
    target = steps_t'($urandom);
    if (roll < 66) begin
      send_item(OP_TICK, target);
    end else if (roll < 88) begin
      if (!sb.moving() || $urandom_range(2) != 0) begin
        span   = int'(sb.tolerance) + 40;
        target = sb.cur_position + steps_t'($urandom_range(2 * span)) - steps_t'(span);
      end
      send_item(OP_SET_TARGET, target);
    end else if (roll < 96) begin
      send_item(OP_CALIBRATE, target);
    end else begin
      send_item(OP_RESERVED, target);
    end
  endtask

  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_HALF_PERIOD;
    cfg_wdata      = '0;
    in_valid       = 1'b0;
    in_operation   = OP_TICK;
    in_target_step = '0;
    out_stall      = 1'b0;
    cycles         = 0;
    tx_idle_pct    = 29;
    rx_idle_pct    = 60;
    sb             = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset settings first
    send_item(OP_RESERVED, '1);
    send_item(OP_SET_TARGET, steps_t'(1));
    send_item(OP_SET_TARGET, steps_t'(-8388608));
    send_item(OP_TICK, '0);
    drain_pipeline();
    write_reg(CFG_HALF_PERIOD, '0);
    send_ticks(2);
    send_item(OP_SET_TARGET, steps_t'(-3));
    send_item(OP_SET_TARGET, steps_t'(8388607));
    send_ticks(4);
    send_item(OP_CALIBRATE, '0);    // calibrate mid-move
    send_ticks(6);
    send_item(OP_CALIBRATE, '0);    // calibrate at rest restarts motion
    send_item(OP_RESERVED, '0);

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      if (seg == 3) begin
        tx_idle_pct = 60;
        rx_idle_pct = 29;
      end else if (seg == 6) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      drain_pipeline();
      write_reg(CFG_HALF_PERIOD, CFG_DATA_W'(half_by_segment[seg]));
      write_reg(CFG_TOLERANCE, CFG_DATA_W'(tol_by_segment[seg]));
      repeat (SEGMENT_ITEMS) send_random_item();
    end

    // finish the current move, then start a short one from rest
    while (sb.moving()) send_item(OP_TICK, '0);
    send_item(OP_SET_TARGET, sb.cur_position + steps_t'(1));
    send_ticks(2);
    drain_pipeline();
    write_reg(CFG_HALF_PERIOD, '0);
    send_ticks(2);

    // far target accepted last, since it keeps the motor busy for good
    send_item(OP_SET_TARGET, steps_t'(8388607));
    send_ticks(3);
    send_item(OP_SET_TARGET, steps_t'(-8388608));
    send_item(OP_CALIBRATE, '0);
    send_ticks(2);

    drain_pipeline();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/sdpg_pkg.sv
hw/rtl/sdpg_core.sv
hw/rtl/stepper_step_dir_pulse_generator.sv
sim/stepper_step_dir_pulse_generator_tb.sv
